[design/srlm_pkg.sv]
// Shared types and constants for the stereo RMS level meter.
// Used by every module of the block; depends on nothing.
package srlm_pkg;

   localparam int SampleW = 16;
   localparam int HalfW   = SampleW - 1;
   localparam int SquareW = 29;
   localparam int SumW    = 40;
   localparam int MeanW   = 30;
   localparam int LevelW  = 15;
   localparam int WeightW = 16;
   localparam int BufferW = 32;

   // restoring divide runs over the halved sum, root takes two mean bits a step
   localparam int DivSteps  = SumW - 1;
   localparam int RootSteps = MeanW / 2;
   localparam int RootRemW  = LevelW + 4;

   localparam logic [WeightW-1:0] WeightReset = 16'd4588;

   // register index decoded from the word address
   localparam logic RegSmoothing = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_LOAD,
      ST_DIVIDE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_BLEND
   } state_type;

   typedef struct packed {
      logic load_div;
      logic step_div;
      logic load_root;
      logic step_root;
   } ds_ctrl_type;

endpackage

[design/stereo_rms_level_meter_core.sv]
// Stereo RMS level meter: squaring lanes, merging accumulator, divide/root unit, smoothing.
// A pair without the last flag passes through accept, square and accumulate.
// A last pair then goes on through load, divide, root load, root, scale and commit to the
// result; the divide and root run as serial loops, and an untaken result stalls the commit.
// Synchronous reset clears the sum, count, level and buffer number and sets the weight to
// 4588; the result register frees input as soon as it loads.
module stereo_rms_level_meter_core #(
   parameter int MAX_PAIRS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // left_sample [15:0], right_sample [31:16]
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rms_level [14:0], smoothed_level [29:15], buffer_number [61:30], zero [63:62]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PairW = $clog2(MAX_PAIRS + 1);
   localparam int CntW  = $clog2(srlm_pkg::DivSteps);
   localparam int LW    = srlm_pkg::LevelW;
   localparam int WW    = srlm_pkg::WeightW;

   srlm_pkg::state_type   state_ff, state_in;
   srlm_pkg::ds_ctrl_type ds_ctrl;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  last_ff;

   logic                  accept, lane_step, merge_acc, merge_clear, commit;
   logic                  scale_ff;
   logic                  slot_free;

   logic [srlm_pkg::SquareW-1:0] square_left, square_right;
   logic [srlm_pkg::SumW-1:0]    sum;
   logic [PairW-1:0]             pairs;
   logic [LW-1:0]                rms;

   logic [WW-1:0]             weight_ff;
   logic [LW-1:0]             level_ff, level_in;
   logic [srlm_pkg::BufferW-1:0] buffers_ff, buffers_in;
   logic [31:0]               p_old_ff;
   logic [30:0]               p_new_ff;
   logic [WW:0]               keep_weight;
   logic [32:0]               blend;
   logic [LW-1:0]             rms_hold_ff;

   logic                      rsp_valid_ff;
   logic [LW-1:0]             out_rms_ff, out_level_ff;
   logic [srlm_pkg::BufferW-1:0] out_buf_ff;
   logic                      csr_write;

   // lanes: one per channel
   srlm_lane u_lane_left (
      .clock  (clock),
      .load   (accept),
      .step   (lane_step),
      .sample (req_tdata[15:0]),
      .square (square_left)
   );

   srlm_lane u_lane_right (
      .clock  (clock),
      .load   (accept),
      .step   (lane_step),
      .sample (req_tdata[31:16]),
      .square (square_right)
   );

   srlm_merge #(
      .MAX_PAIRS (MAX_PAIRS),
      .PairW     (PairW)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accumulate   (merge_acc),
      .clear        (merge_clear),
      .square_left  (square_left),
      .square_right (square_right),
      .sum          (sum),
      .pairs        (pairs)
   );

   srlm_divsqrt #(
      .PairW (PairW)
   ) u_divsqrt (
      .clock (clock),
      .ctrl  (ds_ctrl),
      .sum   (sum),
      .pairs (pairs),
      .rms   (rms)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srlm_pkg::ST_IDLE:      if (req_tvalid) state_in = srlm_pkg::ST_SQUARE;
         srlm_pkg::ST_SQUARE:    state_in = srlm_pkg::ST_ACCUM;
         srlm_pkg::ST_ACCUM:     state_in = last_ff ? srlm_pkg::ST_LOAD : srlm_pkg::ST_IDLE;
         srlm_pkg::ST_LOAD:      state_in = srlm_pkg::ST_DIVIDE;
         srlm_pkg::ST_DIVIDE: begin
            if (cnt_ff == CntW'(srlm_pkg::DivSteps - 1)) state_in = srlm_pkg::ST_ROOT_LOAD;
         end
         srlm_pkg::ST_ROOT_LOAD: state_in = srlm_pkg::ST_ROOT;
         srlm_pkg::ST_ROOT: begin
            if (cnt_ff == CntW'(srlm_pkg::RootSteps - 1)) state_in = srlm_pkg::ST_BLEND;
         end
         srlm_pkg::ST_BLEND:     if (slot_free && !scale_ff) state_in = srlm_pkg::ST_IDLE;
         default:                state_in = srlm_pkg::ST_IDLE;
      endcase
   end

   // control outputs; the blend state spends its first cycle on the products
   always_comb begin
      req_tready  = 1'b0;
      lane_step   = 1'b0;
      merge_acc   = 1'b0;
      merge_clear = 1'b0;
      ds_ctrl     = '0;
      cnt_in      = '0;
      commit      = 1'b0;
      unique case (state_ff)
         srlm_pkg::ST_IDLE:      req_tready = 1'b1;
         srlm_pkg::ST_SQUARE:    lane_step = 1'b1;
         srlm_pkg::ST_ACCUM:     merge_acc = 1'b1;
         srlm_pkg::ST_LOAD: begin
            ds_ctrl.load_div = 1'b1;
            merge_clear      = 1'b1;
         end
         srlm_pkg::ST_DIVIDE: begin
            ds_ctrl.step_div = 1'b1;
            cnt_in           = cnt_ff + CntW'(1);
         end
         srlm_pkg::ST_ROOT_LOAD: ds_ctrl.load_root = 1'b1;
         srlm_pkg::ST_ROOT: begin
            ds_ctrl.step_root = 1'b1;
            cnt_in            = cnt_ff + CntW'(1);
         end
         srlm_pkg::ST_BLEND:     commit = slot_free && !scale_ff;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // scale flag marks the first blend cycle, when products are formed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srlm_pkg::ST_IDLE;
         cnt_ff   <= '0;
         scale_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         scale_ff <= (state_ff == srlm_pkg::ST_ROOT) && (state_in == srlm_pkg::ST_BLEND);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_tlast;
      end
   end

   // smoothing: old*(1-w) + w*rms, round half up
   always_comb begin
      keep_weight = {1'b1, {WW{1'b0}}} - {1'b0, weight_ff};
      blend       = {1'b0, p_old_ff} + {2'b00, p_new_ff} + 33'd32768;
      level_in    = blend[16 +: LW];
      buffers_in  = buffers_ff + srlm_pkg::BufferW'(1);
   end

   always_ff @(posedge clock) begin
      if (scale_ff) begin
         p_old_ff    <= 32'(level_ff) * 32'(keep_weight);
         p_new_ff    <= 31'(weight_ff) * 31'(rms);
         rms_hold_ff <= rms;
      end
   end

   // state that reset sets: weight to its reset value, level and buffer count to zero
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == srlm_pkg::RegSmoothing);

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= srlm_pkg::WeightReset;
         level_ff   <= '0;
         buffers_ff <= '0;
      end else begin
         if (csr_write) begin
            weight_ff <= csr_pwdata[WW-1:0];
         end
         if (commit) begin
            level_ff   <= level_in;
            buffers_ff <= buffers_in;
         end
      end
   end

   // result register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_rms_ff   <= rms_hold_ff;
         out_level_ff <= level_in;
         out_buf_ff   <= buffers_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_buf_ff, out_level_ff, out_rms_ff};

   // register read back
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == srlm_pkg::RegSmoothing) ? {16'd0, weight_ff} : 32'd0;

endmodule

[design/srlm_lane.sv]
// One channel lane: holds a sample, halves it and squares it.
// Depends on srlm_pkg for the sample and square widths.
module srlm_lane (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [srlm_pkg::SampleW-1:0]   sample,
   output logic [srlm_pkg::SquareW-1:0]   square
);

   logic        [srlm_pkg::SampleW-1:0] sample_ff;
   logic        [srlm_pkg::SquareW-1:0] square_ff;
   logic signed [srlm_pkg::HalfW-1:0]   half;
   logic signed [2*srlm_pkg::HalfW-1:0] product;

   // drop the lsb: floor of half the sample
   always_comb begin
      half    = $signed(sample_ff[srlm_pkg::SampleW-1:1]);
      product = half * half;
   end

   // hold the sample, then register its square
   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample;
      end
      if (step) begin
         square_ff <= product[srlm_pkg::SquareW-1:0];
      end
   end

   assign square = square_ff;

endmodule

[design/srlm_merge.sv]
// Merging stage: adds the two lane squares into a saturating buffer sum
// and counts pairs up to the pair limit. Depends on srlm_pkg.
module srlm_merge #(
   parameter int MAX_PAIRS = 1024,
   parameter int PairW     = $clog2(MAX_PAIRS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accumulate,
   input  logic                          clear,
   input  logic [srlm_pkg::SquareW-1:0]  square_left,
   input  logic [srlm_pkg::SquareW-1:0]  square_right,
   output logic [srlm_pkg::SumW-1:0]     sum,
   output logic [PairW-1:0]              pairs
);

   logic [srlm_pkg::SumW-1:0] sum_ff, sum_in;
   logic [PairW-1:0]          pairs_ff, pairs_in;
   logic [srlm_pkg::SquareW:0] pair_add;
   logic [srlm_pkg::SumW:0]   sum_wide;
   logic                      room;

   // add the pair, saturate on carry out, skip once the limit is reached
   always_comb begin
      pair_add = {1'b0, square_left} + {1'b0, square_right};
      sum_wide = {1'b0, sum_ff} + (srlm_pkg::SumW + 1)'(pair_add);
      room     = pairs_ff < PairW'(MAX_PAIRS);
      sum_in   = sum_ff;
      pairs_in = pairs_ff;
      if (clear) begin
         sum_in   = '0;
         pairs_in = '0;
      end else if (accumulate && room) begin
         sum_in   = sum_wide[srlm_pkg::SumW] ? '1 : sum_wide[srlm_pkg::SumW-1:0];
         pairs_in = pairs_ff + PairW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         pairs_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         pairs_ff <= pairs_in;
      end
   end

   assign sum   = sum_ff;
   assign pairs = pairs_ff;

endmodule

[design/srlm_divsqrt.sv]
// End-of-buffer unit: restoring divide of the halved sum by the pair count,
// one bit a cycle, then a digit-by-digit square root. Depends on srlm_pkg.
module srlm_divsqrt #(
   parameter int PairW = 11
) (
   input  logic                          clock,
   input  srlm_pkg::ds_ctrl_type         ctrl,
   input  logic [srlm_pkg::SumW-1:0]     sum,
   input  logic [PairW-1:0]              pairs,
   output logic [srlm_pkg::LevelW-1:0]   rms
);

   localparam int DqW = srlm_pkg::DivSteps;
   localparam int RW  = srlm_pkg::RootRemW;

   logic [DqW-1:0]   dq_ff, dq_in;
   logic [PairW-1:0] rem_ff, rem_in;
   logic [PairW-1:0] div_ff;
   logic             zero_ff;
   logic [PairW:0]   rem_shift;
   logic             div_ge;

   logic [srlm_pkg::MeanW-1:0]  src_ff, src_in;
   logic [RW-1:0]               rrem_ff, rrem_in;
   logic [srlm_pkg::LevelW-1:0] root_ff, root_in;
   logic [RW-1:0]               rrem_shift, trial;
   logic                        root_ge;

   // one restoring divide step: sum/(2*pairs) == (sum>>1)/pairs
   always_comb begin
      rem_shift = {rem_ff, dq_ff[DqW-1]};
      div_ge    = rem_shift >= {1'b0, div_ff};
      dq_in     = {dq_ff[DqW-2:0], div_ge};
      rem_in    = div_ge ? PairW'(rem_shift - {1'b0, div_ff}) : rem_shift[PairW-1:0];
   end

   // one root step: bring down two bits, try (root<<2)|1
   always_comb begin
      rrem_shift = {rrem_ff[RW-3:0], src_ff[srlm_pkg::MeanW-1 -: 2]};
      trial      = {2'b00, root_ff, 2'b01};
      root_ge    = rrem_shift >= trial;
      rrem_in    = root_ge ? (rrem_shift - trial) : rrem_shift;
      root_in    = {root_ff[srlm_pkg::LevelW-2:0], root_ge};
      src_in     = {src_ff[srlm_pkg::MeanW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_div) begin
         dq_ff   <= sum[srlm_pkg::SumW-1:1];
         rem_ff  <= '0;
         div_ff  <= pairs;
         zero_ff <= pairs == '0;
      end else if (ctrl.step_div) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      if (ctrl.load_root) begin
         // an empty buffer reads as zero level
         src_ff  <= zero_ff ? '0 : {1'b0, dq_ff[srlm_pkg::SquareW-1:0]};
         rrem_ff <= '0;
         root_ff <= '0;
      end else if (ctrl.step_root) begin
         src_ff  <= src_in;
         rrem_ff <= rrem_in;
         root_ff <= root_in;
      end
   end

   assign rms = root_ff;

endmodule

[bench/tb_stereo_rms_level_meter_core.sv]
// Self-checking bench for stereo_rms_level_meter_core: drives stereo pairs and
// weight writes, predicts every level result and checks it field by field.
// Depends on srlm_pkg and the core module.
module tb_stereo_rms_level_meter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PairLimit    = 1024;
   localparam int ReportLimit  = 10;
   localparam int SettleCycles = 70;    // margin for a last pair to reach its result
   localparam int HoldCycles   = 400;   // long receiver hold-off
   // longest quiet stretch: hold-off plus two results plus bursts, taken many times over
   localparam int StallLimit   = 5000;
   localparam longint unsigned SumCap = (64'd1 << srlm_pkg::SumW) - 1;

   localparam logic [2:0] WeightAddr = {srlm_pkg::RegSmoothing, 2'b00};
   localparam logic [2:0] SpareAddr  = 3'd4;

   typedef struct {
      logic [15:0] left;
      logic [15:0] right;
      logic        last;
   } pair_item_type;

   typedef struct {
      logic [srlm_pkg::LevelW-1:0]  rms;
      logic [srlm_pkg::LevelW-1:0]  smoothed;
      logic [srlm_pkg::BufferW-1:0] buf_no;
   } level_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   stereo_rms_level_meter_core #(.MAX_PAIRS(PairLimit)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Pending pairs and expected level results
   pair_item_type    pair_queue[$];
   level_result_type level_expect[$];

   // Predicted meter state
   longint unsigned meter_sum;
   int unsigned     meter_count;
   int unsigned     meter_pairs;
   logic [15:0]     meter_level;
   logic [31:0]     meter_buffers;
   logic [15:0]     meter_weight;

   int  fail_count = 0;
   int  stall_cycles = 0;
   int  tx_gap = 0;
   int  rx_gap = 0;
   int  hold_left = 0;
   bit  hold_request = 0;
   bit  steady_tail = 0;
   bit  req_taken = 0;
   pair_item_type next_pair;
   level_result_type want;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned half_square(logic signed [15:0] s);
      longint h;
      h = longint'(s) >>> 1;
      return longint'(h * h);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // Advance the predicted meter by one pair; queue a level result on the last pair
   function automatic void predict_pair(logic [15:0] left, logic [15:0] right, logic last);
      longint unsigned add, rms, w, acc;
      level_result_type res;
      if (meter_pairs < PairLimit) begin
         add = half_square(left) + half_square(right);
         meter_sum = (meter_sum > SumCap - add) ? SumCap : meter_sum + add;
         meter_count += 2;
         meter_pairs++;
      end
      if (!last) return;
      rms = (meter_count != 0) ? floor_root(meter_sum / meter_count) : 0;
      w = meter_weight;
      acc = longint'(meter_level) * (65536 - w) + w * rms + 32768;
      meter_level = acc[31:16];
      meter_buffers++;
      res.rms      = rms[srlm_pkg::LevelW-1:0];
      res.smoothed = meter_level[srlm_pkg::LevelW-1:0];
      res.buf_no   = meter_buffers;
      level_expect.insert(level_expect.size(), res);
      meter_sum   = 0;
      meter_count = 0;
      meter_pairs = 0;
   endfunction

   function automatic void flag_failure(string msg);
      fail_count++;
      if (fail_count <= ReportLimit) $display("mismatch: %s", msg);
   endfunction

   // Sample both channels at the rising edge: predict inputs, check results
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) predict_pair(req_tdata[15:0], req_tdata[31:16], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (level_expect.size() == 0) begin
               flag_failure($sformatf("result with none expected, data %h", rsp_tdata));
            end else begin
               want = level_expect.pop_front();
               if (rsp_tdata[14:0] !== want.rms)
                  flag_failure($sformatf("buffer %0d rms exp %0d got %0d",
                     want.buf_no, want.rms, rsp_tdata[14:0]));
               if (rsp_tdata[29:15] !== want.smoothed)
                  flag_failure($sformatf("buffer %0d smoothed exp %0d got %0d",
                     want.buf_no, want.smoothed, rsp_tdata[29:15]));
               if (rsp_tdata[61:30] !== want.buf_no)
                  flag_failure($sformatf("buffer number exp %0d got %0d",
                     want.buf_no, rsp_tdata[61:30]));
            end
         end
      end
   end

   // Present pairs from the queue, with random idle bursts between items
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 15) == 0) begin
            tx_gap = $urandom_range(1, 9) - 1;
            req_tvalid <= 1'b0;
         end else if (pair_queue.size() != 0) begin
            next_pair = pair_queue.pop_front();
            req_tdata  <= {next_pair.right, next_pair.left};
            req_tlast  <= next_pair.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Drive the result ready: long hold-off on request, else random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left = HoldCycles;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 9) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == WeightAddr) meter_weight = data[srlm_pkg::WeightW-1:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void push_pair(logic [15:0] left, logic [15:0] right, logic last);
      pair_item_type it;
      it.left  = left;
      it.right = right;
      it.last  = last;
      pair_queue.insert(pair_queue.size(), it);
   endfunction

   function automatic void push_buffer(int pairs);
      for (int i = 0; i < pairs; i++) push_pair(pick_sample(), pick_sample(), i == pairs - 1);
   endfunction

   // Queue whole buffers of random length until about the given item count
   function automatic void push_buffers(int items, int max_len);
      int n, len;
      n = 0;
      while (n < items) begin
         len = $urandom_range(1, max_len);
         push_buffer(len);
         n += len;
      end
   endfunction

   // Wait until every pair is taken, every result is back and the core is idle
   task automatic drain_meter();
      while (pair_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (level_expect.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin
      meter_sum     = 0;
      meter_count   = 0;
      meter_pairs   = 0;
      meter_level   = '0;
      meter_buffers = '0;
      meter_weight  = srlm_pkg::WeightReset;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: full-scale, zero, sign and rounding corners at the reset weight
      push_pair(16'h8000, 16'h8000, 1'b1);
      push_pair(16'h7FFF, 16'h7FFF, 1'b1);
      push_pair(16'h0000, 16'h0000, 1'b1);
      push_pair(16'hFFFF, 16'h0001, 1'b1);
      push_pair(16'h5555, 16'hAAAA, 1'b0);
      push_pair(16'hAAAA, 16'h5555, 1'b1);
      push_pair(16'h7FFF, 16'h8000, 1'b0);
      push_pair(16'h8000, 16'h7FFF, 1'b0);
      push_pair(16'h0001, 16'hFFFF, 1'b1);
      push_pair(16'hFFFE, 16'h0002, 1'b1);
      push_pair(16'h8000, 16'h8000, 1'b0);
      push_pair(16'h8000, 16'h8000, 1'b1);
      drain_meter();

      // Random buffers at the reset weight
      push_buffers(110, 8);
      drain_meter();

      // Full weight, with a long result hold-off over short buffers
      csr_write(WeightAddr, {16'($urandom), 16'hFFFF});
      hold_request = 1;
      push_buffers(110, 2);
      drain_meter();

      // Zero weight freezes the level; the spare address is ignored
      csr_write(SpareAddr, $urandom);
      csr_write(WeightAddr, {16'($urandom), 16'h0000});
      push_pair(16'h8000, 16'h8000, 1'b1);
      push_buffers(110, 8);
      drain_meter();

      // Smallest nonzero weight
      csr_write(WeightAddr, 32'h0000_0001);
      push_buffers(110, 8);
      drain_meter();

      // Random weight, one buffer running past the pair limit
      csr_write(WeightAddr, $urandom);
      push_buffers(40, 8);
      push_buffer(PairLimit + 6);
      push_buffers(40, 8);
      drain_meter();

      // Tail with no idling on either side
      csr_write(WeightAddr, {16'($urandom), srlm_pkg::WeightReset});
      steady_tail = 1;
      push_buffers(200, 8);
      drain_meter();

      if (fail_count == 0 && level_expect.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
design/srlm_pkg.sv
design/srlm_lane.sv
design/srlm_merge.sv
design/srlm_divsqrt.sv
design/stereo_rms_level_meter_core.sv
bench/tb_stereo_rms_level_meter_core.sv
